// ----- src/bb2_pkg.sv -----
// Shared types, constants and pixel arithmetic for the 2x2 box blur block.
// Depends on nothing; bb2_rem, the top level and the testbench import it.
package bb2_pkg;

    localparam int CFG_W   = 32;
    localparam int PIX_W   = 16;
    localparam int CHAN_W  = 5;
    localparam int RED_LSB = 11;
    localparam int GRN_LSB = 6;
    localparam int BLU_LSB = 1;

    typedef logic [PIX_W-1:0]  t_pix;
    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [CFG_W-1:0]  t_cfg;

    function automatic t_chan avg4(input t_chan a, input t_chan b,
                                   input t_chan c, input t_chan d);
        logic [CHAN_W+1:0] sum;
        sum = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return sum[CHAN_W+1:2];
    endfunction

    function automatic t_pix blur4(input t_pix a, input t_pix b,
                                   input t_pix c, input t_pix d);
        t_chan rd;
        t_chan gr;
        t_chan bl;
        rd = avg4(a[RED_LSB +: CHAN_W], b[RED_LSB +: CHAN_W],
                  c[RED_LSB +: CHAN_W], d[RED_LSB +: CHAN_W]);
        gr = avg4(a[GRN_LSB +: CHAN_W], b[GRN_LSB +: CHAN_W],
                  c[GRN_LSB +: CHAN_W], d[GRN_LSB +: CHAN_W]);
        bl = avg4(a[BLU_LSB +: CHAN_W], b[BLU_LSB +: CHAN_W],
                  c[BLU_LSB +: CHAN_W], d[BLU_LSB +: CHAN_W]);
        return {rd, gr, bl, 1'b0};
    endfunction

endpackage

// ----- src/bb2_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
module bb2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 320
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bb2_rem.sv -----
// Remainder of the 32-bit frame counter by a fixed modulus, taken by a multiply with the
// rounded-up reciprocal. Uses bb2_pkg; a start registers the value and its product, then the remainder is registered.
module bb2_rem
    import bb2_pkg::*;
#(
    parameter int MODULUS = 240
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  t_cfg                       i_value,
    output logic                       o_busy,
    output logic [$clog2(MODULUS)-1:0] o_rem
);

    localparam int REM_W  = $clog2(MODULUS);
    localparam int RCP_W  = CFG_W + 1;
    localparam int PROD_W = CFG_W + RCP_W;
    localparam int SHIFT  = CFG_W + REM_W;
    localparam int QUO_W  = PROD_W - SHIFT;
    localparam logic [63:0] SCALE    = 64'd1 << SHIFT;
    localparam logic [63:0] RCP_FULL = (SCALE + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    t_cfg              r_value;
    logic [PROD_W-1:0] r_prod;
    logic              r_busy;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  n_rem;
    logic [QUO_W-1:0]  quo;
    t_cfg              quo_mul;
    t_cfg              diff;

    always_comb begin
        quo     = r_prod[PROD_W-1:SHIFT];
        quo_mul = CFG_W'(quo) * CFG_W'(MODULUS);
        diff    = r_value - quo_mul;
        n_rem   = diff[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rem  <= '0;
        end else begin
            r_busy <= i_start;
            if (r_busy) begin
                r_rem <= n_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
            r_prod  <= PROD_W'(i_value) * PROD_W'(RCP);
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

`ifndef ASSERT_OFF
    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_rem} < (REM_W + 1)'(MODULUS))
        else $error("remainder left the range of the modulus");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("remainder unit did not start after a write");
    a_rem_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && !i_start) |=> $stable(r_rem))
        else $error("remainder changed while idle");
`endif

endmodule

// ----- src/box_blur_2x2_rgba5551.sv -----
// Top level of the streaming 2x2 box blur over RGBA5551 pixels.
// Uses bb2_pkg, bb2_ram (line store) and bb2_rem (frame counter remainders).
//
// Pixels enter in raster order on the slave stream, one word per pixel;
// tuser marks the first pixel of a frame and restarts the position at row 0,
// column 0. Each pixel closes a 2x2 window whose upper-left position is the
// result position. A result word leaves on the master stream when that position
// lies inside the region bounded by frame_count mod FRAME_HEIGHT rows and
// frame_count mod FRAME_WIDTH columns; other pixels produce no word.
// One pixel is taken per cycle while tready is high. An accepted pixel passes
// the line store read stage, then the blur and the output register.
// When the receiver stalls, the result is held and one more
// pixel is taken into the read stage before tready falls.
// A write of frame_count starts two remainder units; tready stays low in the
// write cycle and in the cycle after it while they finish. After reset the
// position is row 0, column 0, frame_count is zero, and no result region
// exists until written.
// The line store needs no clearing: row 0 fills it before any read is used.
module box_blur_2x2_rgba5551
    import bb2_pkg::*;
#(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  t_cfg i_cfg_wdata,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // pixel_in
    input  t_pix i_s_axis_tdata,
    // frame_start
    input  logic i_s_axis_tuser,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // dest_row, dest_col, pixel_out, zero fill
    output logic [((($clog2(FRAME_HEIGHT) + $clog2(FRAME_WIDTH) + PIX_W) + 7) / 8) * 8 - 1:0]
                 o_m_axis_tdata
);

    localparam int ROW_W     = $clog2(FRAME_HEIGHT);
    localparam int COL_W     = $clog2(FRAME_WIDTH);
    localparam int OUT_W     = ROW_W + COL_W + PIX_W;
    localparam int OUT_PAD_W = ((OUT_W + 7) / 8) * 8;

    logic             busy_row;
    logic             busy_col;
    logic [ROW_W-1:0] lim_row;
    logic [COL_W-1:0] lim_col;

    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] n_row;
    logic [COL_W-1:0] n_col;

    logic             r_s1_valid;
    t_pix             r_s1_pixel;
    logic [ROW_W-1:0] r_s1_row;
    logic [COL_W-1:0] r_s1_col;
    t_pix             above;
    t_pix             r_left;
    t_pix             r_above_left;

    logic             r_out_valid;
    logic [ROW_W-1:0] r_out_row;
    logic [COL_W-1:0] r_out_col;
    t_pix             r_out_pixel;

    logic             s_ready;
    logic             in_acc;
    logic             s1_adv;
    logic             s1_fire;
    logic             emit;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;

    bb2_rem #(.MODULUS(FRAME_HEIGHT)) u_rem_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_value (i_cfg_wdata),
        .o_busy  (busy_row),
        .o_rem   (lim_row)
    );

    bb2_rem #(.MODULUS(FRAME_WIDTH)) u_rem_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_value (i_cfg_wdata),
        .o_busy  (busy_col),
        .o_rem   (lim_col)
    );

    assign s1_adv  = !r_out_valid || i_m_axis_tready;
    assign s1_fire = r_s1_valid && s1_adv;
    assign s_ready = !busy_row && !busy_col && !i_cfg_we && (!r_s1_valid || s1_adv);
    assign in_acc  = i_s_axis_tvalid && s_ready;

    always_comb begin
        cur_row = i_s_axis_tuser ? '0 : r_row;
        cur_col = i_s_axis_tuser ? '0 : r_col;
        n_row   = cur_row;
        n_col   = cur_col + COL_W'(1);
        if (cur_col == COL_W'(FRAME_WIDTH - 1)) begin
            n_col = '0;
            if (cur_row == ROW_W'(FRAME_HEIGHT - 1)) begin
                n_row = '0;
            end else begin
                n_row = cur_row + ROW_W'(1);
            end
        end
    end

    bb2_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_WIDTH)) u_line (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (cur_col),
        .i_wdata (i_s_axis_tdata),
        .i_re    (in_acc),
        .i_raddr (cur_col),
        .o_rdata (above)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_s1_valid   <= 1'b0;
            r_left       <= '0;
            r_above_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_row      <= n_row;
                r_col      <= n_col;
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_left       <= r_s1_pixel;
                r_above_left <= above;
            end
            if (s1_adv) begin
                r_out_valid <= s1_fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pixel <= i_s_axis_tdata;
            r_s1_row   <= cur_row;
            r_s1_col   <= cur_col;
        end
        if (s1_fire && emit) begin
            r_out_row   <= row_m1;
            r_out_col   <= col_m1;
            r_out_pixel <= blur4(r_above_left, above, r_left, r_s1_pixel);
        end
    end

    assign row_m1 = r_s1_row - ROW_W'(1);
    assign col_m1 = r_s1_col - COL_W'(1);
    assign emit   = (r_s1_row != '0) && (r_s1_col != '0) &&
                    (row_m1 < lim_row) && (col_m1 < lim_col);

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_PAD_W'({r_out_pixel, r_out_col, r_out_row});

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy_row || busy_col) |-> !o_s_axis_tready)
        else $error("pixel taken while the region bounds were being computed");
    a_out_in_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_row < lim_row) && (r_out_col < lim_col))
        else $error("result lies outside the blurred region");
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= ROW_W'(FRAME_HEIGHT - 1)) && (r_col <= COL_W'(FRAME_WIDTH - 1)))
        else $error("pixel position left the frame");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !s1_fire)
        else $error("read stage advanced over a stalled result");
    a_alpha_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && emit |=> !r_out_pixel[0])
        else $error("alpha bit set in a blurred pixel");
`endif

endmodule

// ----- dv/tb_box_blur_2x2_rgba5551.sv -----
// Self-checking testbench for box_blur_2x2_rgba5551: raster frames of RGBA5551 words in,
// blurred words with row and column out, predicted by a small scoreboard class.
// Depends on bb2_pkg and the box_blur_2x2_rgba5551 RTL only.
module tb_box_blur_2x2_rgba5551;
    import bb2_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_W   = 320;
    localparam int FRAME_H   = 240;
    localparam int ROW_W     = 8;
    localparam int COL_W     = 9;
    localparam int OUT_W     = ((ROW_W + COL_W + PIX_W + 7) / 8) * 8;
    localparam int MAX_CYCLE = 100000;
    localparam int HOLD_LEN  = 400;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_pix             pix;
    } t_blur_word;

    class blur_scoreboard;
        t_pix       line_mem [FRAME_W];
        t_pix       above_left;
        t_pix       left_pix;
        int         row;
        int         col;
        t_cfg       frame_count;
        t_blur_word blurred_q[$];
        int         errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            above_left  = '0;
            left_pix    = '0;
            row         = 0;
            col         = 0;
            frame_count = '0;
            errors      = 0;
        endfunction

        function void set_frame_count(t_cfg value);
            frame_count = value;
        endfunction

        function int pending();
            return blurred_q.size();
        endfunction

        function t_pix blend_window(t_pix a, t_pix b, t_pix c, t_pix d);
            t_pix res;
            int   sum;
            int   lsb;
            res = '0;
            for (int k = 0; k < 3; k++) begin
                lsb = RED_LSB - k * CHAN_W;
                sum = int'(a[lsb +: CHAN_W]) + int'(b[lsb +: CHAN_W])
                    + int'(c[lsb +: CHAN_W]) + int'(d[lsb +: CHAN_W]);
                res[lsb +: CHAN_W] = CHAN_W'(sum >> 2);
            end
            return res;
        endfunction

        function void note_pixel(t_pix px, bit start);
            t_pix       above;
            int         lim_r;
            int         lim_c;
            t_blur_word w;
            if (start) begin
                row = 0;
                col = 0;
            end
            above = line_mem[col];
            lim_r = int'(frame_count % 32'(FRAME_H));
            lim_c = int'(frame_count % 32'(FRAME_W));
            if (row >= 1 && col >= 1 && row - 1 < lim_r && col - 1 < lim_c) begin
                w.row = ROW_W'(row - 1);
                w.col = COL_W'(col - 1);
                w.pix = blend_window(above_left, above, left_pix, px);
                blurred_q.push_back(w);
            end
            above_left    = above;
            line_mem[col] = px;
            left_pix      = px;
            col++;
            if (col >= FRAME_W) begin
                col = 0;
                row++;
                if (row >= FRAME_H) begin
                    row = 0;
                end
            end
        endfunction

        function void check_word(logic [OUT_W-1:0] word);
            t_blur_word       want;
            logic [ROW_W-1:0] got_row;
            logic [COL_W-1:0] got_col;
            t_pix             got_pix;
            got_row = word[ROW_W-1:0];
            got_col = word[ROW_W +: COL_W];
            got_pix = word[ROW_W + COL_W +: PIX_W];
            if (blurred_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, word);
                errors++;
                return;
            end
            want = blurred_q.pop_front();
            if (got_row !== want.row) begin
                $display("%0t: dest_row expected %0d actual %0d", $time, want.row, got_row);
                errors++;
            end
            if (got_col !== want.col) begin
                $display("%0t: dest_col expected %0d actual %0d", $time, want.col, got_col);
                errors++;
            end
            if (got_pix !== want.pix) begin
                $display("%0t: pixel_out expected %h actual %h", $time, want.pix, got_pix);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg             i_cfg_wdata;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    t_pix             i_s_axis_tdata;
    logic             i_s_axis_tuser;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;

    blur_scoreboard sb;
    int             cycle_cnt;
    bit             tx_idle;
    int             burst_left;
    int             rx_mode;
    int             rx_phase;
    int             hold_cnt;
    bit             held_once;

    box_blur_2x2_rgba5551 #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > MAX_CYCLE) begin
            $display("box_blur_2x2_rgba5551 test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            sb.note_pixel(i_s_axis_tdata, i_s_axis_tuser);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_word(o_m_axis_tdata);
        end
    end

    // The first result word seen triggers one long hold so the block backs up.
    initial begin
        bit rdy;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_phase++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (!held_once && o_m_axis_tvalid === 1'b1) begin
                held_once = 1'b1;
                hold_cnt  = HOLD_LEN;
                rdy       = 1'b0;
            end else begin
                case (rx_mode)
                    0: begin
                        rdy = 1'b1;
                    end
                    1: begin
                        rdy = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        rdy = ((rx_phase % 7) < 4);
                    end
                    default: begin
                        rdy = ($urandom_range(0, 9) < 3);
                    end
                endcase
            end
            i_m_axis_tready <= rdy;
        end
    end

    task automatic push_pixel(t_pix px, bit start);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        i_s_axis_tuser  <= start;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        if (tx_idle) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                burst_left = $urandom_range(1, 30);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic stop_stream();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tuser  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_frame_count(t_cfg value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_frame_count(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic t_pix pick_pixel();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
            return '1;
        end else if (sel == 1) begin
            return '0;
        end
        return t_pix'($urandom());
    endfunction

    task automatic send_frame(bit lead_start, int count, bit noisy);
        bit start;
        for (int i = 0; i < count; i++) begin
            start = (i == 0) ? lead_start : (noisy && $urandom_range(0, 399) == 0);
            push_pixel(pick_pixel(), start);
        end
        stop_stream();
    endtask

    initial begin
        t_cfg fixed_cfg [6];
        t_cfg fc;
        int   count;
        fixed_cfg = '{32'd0, 32'd320, 32'd1, 32'hFFFF_FFFF, 32'd76799, 32'd241};
        sb              = new();
        cycle_cnt       = 0;
        tx_idle         = 1'b0;
        burst_left      = 0;
        rx_mode         = 0;
        rx_phase        = 0;
        hold_cnt        = 0;
        held_once       = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pixels right after reset with no frame start, then restarts mid-row.
        push_pixel(16'h0000, 1'b0);
        push_pixel(16'hFFFF, 1'b0);
        push_pixel(16'hAAAA, 1'b0);
        push_pixel(16'h5555, 1'b0);
        push_pixel(16'hFFFF, 1'b1);
        push_pixel(16'h0001, 1'b0);
        push_pixel(16'hFFFE, 1'b1);
        push_pixel(16'h8000, 1'b1);
        push_pixel(16'h7FFF, 1'b0);
        push_pixel(16'h07C0, 1'b0);
        push_pixel(16'h003E, 1'b0);
        push_pixel(16'hF800, 1'b0);
        stop_stream();
        wait_drained();

        // The start of one frame in segments, each under its own frame_count; the last two reach row 1.
        for (int p = 0; p < 12; p++) begin
            fc = (p < 6) ? t_cfg'($urandom()) : fixed_cfg[p - 6];
            write_frame_count(fc);
            tx_idle = (p % 3 != 2);
            rx_mode = p % 4;
            count   = 32;
            send_frame(p == 0, count, 1'b0);
            wait_drained();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("box_blur_2x2_rgba5551 test passed");
        end else begin
            $display("box_blur_2x2_rgba5551 test failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/bb2_pkg.sv
src/bb2_ram.sv
src/bb2_rem.sv
src/box_blur_2x2_rgba5551.sv
dv/tb_box_blur_2x2_rgba5551.sv
